### design/toml_token_lexer_defines.svh
// Assertion macros for the TOML token lexer.
`ifndef TOML_TOKEN_LEXER_DEFINES_SVH
`define TOML_TOKEN_LEXER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define TTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttl assertion failed");
// Next-cycle implication.
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttl assertion failed");
`else
`define TTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/ttl_pkg.sv
// Package for the TOML token lexer: token kinds, character codes, result record.
`default_nettype none
package ttl_pkg;

    localparam int LENGTH_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_RESULTS       = 3;

    typedef enum logic [3:0] {
        K_END       = 4'd0,
        K_INVALID   = 4'd1,
        K_EQUALS    = 4'd2,
        K_SYMBOL    = 4'd3,
        K_COMMENT   = 4'd4,
        K_LBRACKET  = 4'd5,
        K_RBRACKET  = 4'd6,
        K_LCURLY    = 4'd7,
        K_RCURLY    = 4'd8,
        K_COMMA     = 4'd9,
        K_DOT       = 4'd10,
        K_NEWLINE   = 4'd11,
        K_BASIC     = 4'd12,
        K_MLBASIC   = 4'd13,
        K_LITERAL   = 4'd14,
        K_MLLITERAL = 4'd15
    } token_kind_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    // One result as it leaves the block.
    typedef struct packed {
        logic        last;
        logic [15:0] column;
        logic [15:0] line;
        logic [15:0] length;
        token_kind_t kind;
    } token_t;

    // Bare-key characters: alphanumerics, underscore, dash and dot.
    function automatic logic is_sym(input logic [7:0] c);
        is_sym = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER || c == CH_DASH ||
                 c == CH_DOT;
    endfunction

endpackage
`default_nettype wire

### design/toml_token_lexer.sv
// Top level of the TOML token lexer: byte input stage, lexer state and result buffer.
//
// Usage:
//   Slave channel s_*: one document byte per transfer. s_tdata carries the byte,
//   s_tuser[0] says whether the byte is present, and s_tlast ends the document
//   after this transfer (an end-only transfer has s_tuser[0] low, s_tlast high).
//   Master channel m_*: one token per transfer, with kind, length and the line
//   and column of its first byte; m_tlast marks the last token caused by one
//   input transfer. One input transfer gives zero to three tokens.
//   Flow: a byte is held in the input register and lexed once the result buffer
//   is empty or about to be; its tokens are registered in that buffer and leave on m_*.
//   Throughput: one byte per cycle while each byte gives at most one token and
//   m_tready is high; a byte that gives two or three tokens holds the input
//   register while the three-entry result buffer drains one token a cycle.
//   Stall: when m_tready is low the buffered tokens hold; one more byte is still
//   taken into the input register, after which s_tready drops.
//   Reset: line and column return to zero and the lexer goes idle between
//   tokens; the same happens after every s_tlast transfer, so each document
//   starts at line 0, column 0. Lengths, lines and columns saturate.
`default_nettype none
`include "toml_token_lexer_defines.svh"
module toml_token_lexer #(
    parameter int LENGTH_BITS   = ttl_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS = ttl_pkg::POSITION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,   // end_of_content
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [3:0] token_kind, [19:4] token_length,
                                        // [35:20] start_line, [51:36] start_column,
                                        // [55:52] zero
    output logic             m_tlast    // last_of_run
);
    import ttl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_CR, M_COMMENT, M_SYMBOL, M_DQ_OPEN, M_BASIC, M_MLBASIC,
        M_SQ_OPEN, M_LITERAL, M_MLLITERAL
    } lex_mode_t;

    localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_bv_reg;
    logic       in_eoc_reg;

    // Lexer state
    lex_mode_t                mode_reg, mode_next;
    logic [LENGTH_BITS-1:0]   run_reg, run_next;
    logic [1:0]               qc_reg, qc_next;
    logic                     esc_reg, esc_next;
    logic [POSITION_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] tok_col_reg, tok_col_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;

    // Result buffer
    token_t     slot_reg [MAX_RESULTS];
    token_t     slot_next [MAX_RESULTS];
    logic [1:0] pend_reg;
    logic [1:0] rd_ptr_reg;
    logic [1:0] n_new;

    logic process;

    // Candidate tokens in emission order: close, single, flush, end.
    logic   cand_v [4];
    token_t cand [4];

    // Intermediate lexing values
    lex_mode_t                m1;
    logic [LENGTH_BITS-1:0]   r1, grown;
    logic [1:0]               q1;
    logic                     e1;
    logic [POSITION_BITS-1:0] tl1, tc1;
    logic                     restart;
    logic                     close_v, single_v, flush_v;
    token_kind_t              close_kind, single_kind, flush_kind;
    logic [LENGTH_BITS-1:0]   close_len;

    // ---------------------------------------------------------------
    // Handshake: lex the held byte when the buffer is empty or about to be
    // ---------------------------------------------------------------
    assign process  = in_valid_reg &&
                      (pend_reg == 2'd0 || (pend_reg == 2'd1 && m_tready));
    assign s_tready = !in_valid_reg || process;
    assign m_tvalid = (pend_reg != 2'd0);

    always_comb
    begin
        m_tdata = {4'd0, slot_reg[rd_ptr_reg].column, slot_reg[rd_ptr_reg].line,
                   slot_reg[rd_ptr_reg].length, slot_reg[rd_ptr_reg].kind};
        m_tlast = slot_reg[rd_ptr_reg].last;
    end

    // ---------------------------------------------------------------
    // Lexing of one byte, then end-of-document flush
    // ---------------------------------------------------------------
    assign grown = (run_reg == '1) ? run_reg : run_reg + LEN_ONE;

    always_comb
    begin
        close_v     = 1'b0;
        close_kind  = K_INVALID;
        close_len   = run_reg;
        restart     = 1'b0;
        single_v    = 1'b0;
        single_kind = K_INVALID;
        m1          = mode_reg;
        r1          = run_reg;
        q1          = qc_reg;
        e1          = esc_reg;
        tl1         = tok_line_reg;
        tc1         = tok_col_reg;

        if (in_bv_reg)
        begin
            case (mode_reg)
                M_CR:
                begin
                    close_v = 1'b1;
                    if (in_char_reg == CH_LF)
                    begin
                        close_kind = K_NEWLINE;
                        close_len  = grown;
                        m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
                    end
                    else
                    begin
                        close_kind = K_INVALID;
                        restart    = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (in_char_reg == CH_LF)
                    begin
                        close_v    = 1'b1;
                        close_kind = K_COMMENT;
                        restart    = 1'b1;
                    end
                    else
                        r1 = grown;
                end
                M_SYMBOL:
                begin
                    if (is_sym(in_char_reg))
                        r1 = grown;
                    else
                    begin
                        close_v    = 1'b1;
                        close_kind = K_SYMBOL;
                        restart    = 1'b1;
                    end
                end
                M_DQ_OPEN, M_SQ_OPEN:
                begin
                    if (in_char_reg == ((mode_reg == M_DQ_OPEN) ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        r1 = grown;
                        if (qc_reg == 2'd1)
                            q1 = 2'd2;
                        else
                        begin
                            q1 = 2'd0;
                            m1 = (mode_reg == M_DQ_OPEN) ? M_MLBASIC : M_MLLITERAL;
                        end
                    end
                    else if (qc_reg == 2'd2)
                    begin
                        // empty quotes close before this byte
                        close_v    = 1'b1;
                        close_kind = (mode_reg == M_DQ_OPEN) ? K_BASIC : K_LITERAL;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        q1 = 2'd0;
                        r1 = grown;
                        if (mode_reg == M_DQ_OPEN)
                        begin
                            m1 = M_BASIC;
                            e1 = (in_char_reg == CH_BSLASH);
                        end
                        else
                            m1 = M_LITERAL;
                    end
                end
                M_BASIC:
                begin
                    r1 = grown;
                    if (esc_reg)
                        e1 = 1'b0;
                    else if (in_char_reg == CH_BSLASH)
                        e1 = 1'b1;
                    else if (in_char_reg == CH_DQUOTE)
                    begin
                        close_v    = 1'b1;
                        close_kind = K_BASIC;
                        close_len  = grown;
                        m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
                    end
                end
                M_MLBASIC:
                begin
                    r1 = grown;
                    if (esc_reg)
                    begin
                        e1 = 1'b0; q1 = 2'd0;
                    end
                    else if (in_char_reg == CH_BSLASH)
                    begin
                        e1 = 1'b1; q1 = 2'd0;
                    end
                    else if (in_char_reg == CH_DQUOTE)
                    begin
                        q1 = qc_reg + 2'd1;
                        if (q1 == 2'd3)
                        begin
                            close_v    = 1'b1;
                            close_kind = K_MLBASIC;
                            close_len  = grown;
                            m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
                        end
                    end
                    else
                        q1 = 2'd0;
                end
                M_LITERAL:
                begin
                    r1 = grown;
                    if (in_char_reg == CH_SQUOTE)
                    begin
                        close_v    = 1'b1;
                        close_kind = K_LITERAL;
                        close_len  = grown;
                        m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
                    end
                end
                M_MLLITERAL:
                begin
                    r1 = grown;
                    if (in_char_reg == CH_SQUOTE)
                    begin
                        q1 = qc_reg + 2'd1;
                        if (q1 == 2'd3)
                        begin
                            close_v    = 1'b1;
                            close_kind = K_MLLITERAL;
                            close_len  = grown;
                            m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
                        end
                    end
                    else
                        q1 = 2'd0;
                end
                default:
                    restart = 1'b1;
            endcase
        end

        // Start of a new token from the idle state
        if (restart)
        begin
            m1 = M_IDLE; r1 = '0; q1 = 2'd0; e1 = 1'b0;
            if (in_char_reg != CH_SPACE && in_char_reg != CH_TAB)
            begin
                tl1 = line_reg;
                tc1 = col_reg;
                r1  = LEN_ONE;
            end
            case (in_char_reg)
                CH_SPACE, CH_TAB: ;
                CH_CR:     m1 = M_CR;
                CH_HASH:   m1 = M_COMMENT;
                CH_DQUOTE: begin m1 = M_DQ_OPEN; q1 = 2'd1; end
                CH_SQUOTE: begin m1 = M_SQ_OPEN; q1 = 2'd1; end
                CH_LF:     begin single_v = 1'b1; single_kind = K_NEWLINE;  end
                CH_LBRACK: begin single_v = 1'b1; single_kind = K_LBRACKET; end
                CH_RBRACK: begin single_v = 1'b1; single_kind = K_RBRACKET; end
                CH_LCURLY: begin single_v = 1'b1; single_kind = K_LCURLY;   end
                CH_RCURLY: begin single_v = 1'b1; single_kind = K_RCURLY;   end
                CH_EQUALS: begin single_v = 1'b1; single_kind = K_EQUALS;   end
                CH_COMMA:  begin single_v = 1'b1; single_kind = K_COMMA;    end
                CH_DOT:    begin single_v = 1'b1; single_kind = K_DOT;      end
                default:
                begin
                    if (is_sym(in_char_reg))
                        m1 = M_SYMBOL;
                    else
                    begin
                        single_v    = 1'b1;
                        single_kind = K_INVALID;
                    end
                end
            endcase
            if (single_v)
                r1 = '0;
        end

        // Position counters
        line_next = line_reg;
        col_next  = col_reg;
        if (in_bv_reg)
        begin
            if (in_char_reg == CH_LF)
            begin
                if (line_reg != '1)
                    line_next = line_reg + POS_ONE;
                col_next = '0;
            end
            else if (col_reg != '1)
                col_next = col_reg + POS_ONE;
        end

        // End of document: flush any open token
        flush_v    = in_eoc_reg && (m1 != M_IDLE);
        flush_kind = K_INVALID;
        case (m1)
            M_COMMENT: flush_kind = K_COMMENT;
            M_SYMBOL:  flush_kind = K_SYMBOL;
            M_DQ_OPEN: flush_kind = (q1 == 2'd2) ? K_BASIC : K_INVALID;
            M_SQ_OPEN: flush_kind = (q1 == 2'd2) ? K_LITERAL : K_INVALID;
            default:   flush_kind = K_INVALID;
        endcase

        cand_v[0] = close_v;
        cand[0]   = '{last: 1'b0, column: 16'(tok_col_reg), line: 16'(tok_line_reg),
                      length: 16'(close_len), kind: close_kind};
        cand_v[1] = single_v;
        cand[1]   = '{last: 1'b0, column: 16'(col_reg), line: 16'(line_reg),
                      length: 16'd1, kind: single_kind};
        cand_v[2] = flush_v;
        cand[2]   = '{last: 1'b0, column: 16'(tc1), line: 16'(tl1),
                      length: 16'(r1), kind: flush_kind};
        cand_v[3] = in_eoc_reg;
        cand[3]   = '{last: 1'b0, column: 16'(col_next), line: 16'(line_next),
                      length: 16'd0, kind: K_END};

        // Next state; end of document returns to reset values
        if (in_eoc_reg)
        begin
            mode_next     = M_IDLE;
            run_next      = '0;
            qc_next       = 2'd0;
            esc_next      = 1'b0;
            tok_line_next = '0;
            tok_col_next  = '0;
            line_next     = '0;
            col_next      = '0;
        end
        else
        begin
            mode_next     = m1;
            run_next      = r1;
            qc_next       = q1;
            esc_next      = e1;
            tok_line_next = tl1;
            tok_col_next  = tc1;
        end
    end

    // Compact valid candidates into the buffer slots, tag the last one
    always_comb
    begin
        n_new = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_next[i] = cand[3];
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n_new != 2'd3)
            begin
                slot_next[n_new] = cand[i];
                n_new = n_new + 2'd1;
            end
        end
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_next[i].last = (2'(i) == n_new - 2'd1);
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= M_IDLE;
            run_reg      <= '0;
            qc_reg       <= 2'd0;
            esc_reg      <= 1'b0;
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            pend_reg     <= 2'd0;
            rd_ptr_reg   <= 2'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
            begin
                mode_reg     <= mode_next;
                run_reg      <= run_next;
                qc_reg       <= qc_next;
                esc_reg      <= esc_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                line_reg     <= line_next;
                col_reg      <= col_next;
                pend_reg     <= n_new;
                rd_ptr_reg   <= 2'd0;
            end
            else if (m_tvalid && m_tready)
            begin
                pend_reg   <= pend_reg - 2'd1;
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_bv_reg   <= s_tuser[0];
            in_eoc_reg  <= s_tlast;
        end
        if (process)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TTL_ASSERT_IMPLY(a_slot_range, clk, rst_n, m_tvalid,
        ({1'b0, rd_ptr_reg} + {1'b0, pend_reg}) <= 3'd3)
    `TTL_ASSERT_NEXT(a_run_continues, clk, rst_n, m_tvalid && m_tready && !m_tlast,
        m_tvalid)
    `TTL_ASSERT_NEXT(a_doc_restart, clk, rst_n, process && in_eoc_reg,
        line_reg == '0 && col_reg == '0 && mode_reg == M_IDLE)

endmodule
`default_nettype wire
